/* src/bfei_pkg.sv */
// Shared types, codes and bit-order helpers of the bit field extract/insert block.
// No dependencies; bfei_field and the top level import this package.
package bfei_pkg;

	// Default buffer size in bytes.
	localparam int BUF_BYTES_DEF = 64;

	// A field starts below bit 512 and is at most 64 bits wide, so it never reaches
	// past bit 575: nine 64-bit words hold everything that can be addressed.
	localparam int MAX_WORDS = 9;

	localparam logic [6:0] MAX_WIDTH = 7'd64;
	localparam logic [6:0] BYTE_WIDTH = 7'd8;

	typedef enum logic [1:0] {
		REQ_WR_BYTE = 2'd0,
		REQ_RD_BYTE = 2'd1,
		REQ_EXTRACT = 2'd2,
		REQ_INSERT  = 2'd3
	} req_e_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_WIDTH = 2'd1,
		ST_RANGE = 2'd2
	} status_e_t;

	// Field geometry handed from the control to the shift and merge datapath.
	typedef struct packed {
		logic       msb;
		logic [5:0] shift;
		logic [6:0] width;
	} fld_ctl_t;

	// Reverses the bit order inside every byte of a two-word window.
	function automatic logic [127:0] brev_bytes(input logic [127:0] w);
		logic [127:0] r;
		for (int j = 0; j < 16; j++) begin
			for (int b = 0; b < 8; b++) begin
				r[8*j+b] = w[8*j+7-b];
			end
		end
		return r;
	endfunction

	function automatic logic [63:0] rev64(input logic [63:0] w);
		logic [63:0] r;
		for (int i = 0; i < 64; i++) begin
			r[i] = w[63-i];
		end
		return r;
	endfunction

endpackage

/* src/bfei_bank.sv */
// One bank of 64-bit words of the byte buffer: synchronous RAM, one write and
// one registered read port. Depends on nothing.
module bfei_bank #(
	parameter int DEPTH = 5,
	parameter int AW = 3
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [63:0]   wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [63:0]   rdata
);

	logic [63:0] mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* src/bfei_field.sv */
// Shift and merge datapath: pulls a field out of a two-word window and merges
// a new field into it, in either bit order. Depends on bfei_pkg.
module bfei_field (
	input  bfei_pkg::fld_ctl_t ctl,
	input  logic [63:0]        value,
	input  logic [127:0]       win,
	output logic [63:0]        extracted,
	output logic [127:0]       win_new
);
	import bfei_pkg::*;

	logic [127:0] win_ord;
	logic [63:0]  mask;
	logic [63:0]  fwd;
	logic [63:0]  ins;
	logic [127:0] ins_pos;
	logic [127:0] mask_pos;
	logic [127:0] merged;
	logic [6:0]   rest;

	// In MSB-first order, reversing each byte makes window bit i equal buffer bit i.
	assign win_ord = ctl.msb ? brev_bytes(win) : win;
	assign rest    = MAX_WIDTH - ctl.width;
	assign mask    = {64{1'b1}} >> rest;
	assign fwd     = win_ord[ctl.shift +: 64];

	// In MSB-first order the first buffer bit of the field is the top value bit.
	assign extracted = ctl.msb ? (rev64(fwd) >> rest) : (fwd & mask);
	assign ins       = ctl.msb ? rev64(value << rest) : (value & mask);

	assign ins_pos  = {64'd0, ins} << ctl.shift;
	assign mask_pos = {64'd0, mask} << ctl.shift;
	assign merged   = (win_ord & ~mask_pos) | ins_pos;
	assign win_new  = ctl.msb ? brev_bytes(merged) : merged;

endmodule

/* src/bit_field_extract_insert_top.sv */
// Top level of the bit field extract/insert block: request decode, two-bank
// word buffer and result register. Depends on bfei_pkg, bfei_bank, bfei_field.
//
// Usage:
//   A request word is taken at a rising edge with start high and busy low.
//   Byte write/read use byte_addr and byte_data; extract and insert use
//   bit_offset, bit_width, msb_first and field_value.
//   The buffer is kept as 64-bit words split into an even and an odd bank, so
//   the two words a field can touch are read together and written back
//   together. The edge that takes the request also issues the bank reads;
//   the next edge merges and writes back, and loads the result.
//   Every request gives exactly one result word: done is high for one cycle,
//   loaded at the edge that writes back, with result_data and status.
//   Busy stays high through the read cycle, so a new request waits until the
//   last one is written back; this also keeps a new read off a word being written.
//   The receiver cannot hold off results, and the block never waits on it.
//   Reset clears the control state only; the buffer content is undefined
//   until written, and no clearing pass runs.
module bit_field_extract_insert_top #(
	parameter int BUF_BYTES = bfei_pkg::BUF_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  req_type,
	input  logic        msb_first,
	input  logic [8:0]  bit_offset,
	input  logic [6:0]  bit_width,
	input  logic [63:0] field_value,
	input  logic [5:0]  byte_addr,
	input  logic [7:0]  byte_data,
	output logic        done,
	output logic [63:0] result_data,
	output logic [1:0]  status
);
	import bfei_pkg::*;

	localparam int NW_ALL = (BUF_BYTES + 7) / 8;
	localparam int NW = (NW_ALL < MAX_WORDS) ? NW_ALL : MAX_WORDS;
	localparam int BD = (NW + 1) / 2;
	localparam int AW = (BD > 1) ? $clog2(BD) : 1;
	localparam int EW = ($clog2(8 * BUF_BYTES + 1) > 10) ? $clog2(8 * BUF_BYTES + 1) : 10;

	req_e_t     req;
	logic       acc;
	logic       is_byte;
	logic [8:0] eff_off;
	logic [6:0] eff_wid;
	logic       eff_msb;
	logic [63:0] eff_val;
	logic [EW-1:0] end_pos;
	logic       addr_ok;
	status_e_t  st_d;
	logic [2:0] w_lo;
	logic [3:0] w_hi;
	logic [2:0] ea_full;
	logic [1:0] oa_full;
	logic       eok;
	logic       ook;
	logic [AW-1:0] ea;
	logic [AW-1:0] oa;

	logic       v_s1;
	fld_ctl_t   ctl_s1;
	logic [63:0] val_s1;
	status_e_t  st_s1;
	logic       wr_s1;
	logic       rd_s1;
	logic       odd_lo_s1;
	logic [AW-1:0] ea_s1;
	logic [AW-1:0] oa_s1;
	logic       eok_s1;
	logic       ook_s1;

	logic [63:0]  even_rd;
	logic [63:0]  odd_rd;
	logic [127:0] win;
	logic [127:0] win_new;
	logic [63:0]  extracted;
	logic         we_even;
	logic         we_odd;

	logic        done_q;
	logic [63:0] result_q;
	status_e_t   status_q;

	assign busy = v_s1;
	assign acc  = start & ~busy;
	assign req  = req_e_t'(req_type);

	// Byte requests run as 8-bit LSB-first fields on the byte's bit position.
	assign is_byte = (req == REQ_WR_BYTE) || (req == REQ_RD_BYTE);
	assign eff_off = is_byte ? {byte_addr, 3'b000} : bit_offset;
	assign eff_wid = is_byte ? BYTE_WIDTH : bit_width;
	assign eff_msb = is_byte ? 1'b0 : msb_first;
	assign eff_val = is_byte ? {56'd0, byte_data} : field_value;

	assign end_pos = EW'(bit_offset) + EW'(bit_width);
	assign addr_ok = EW'(byte_addr) < EW'(BUF_BYTES);

	always_comb begin
		if (is_byte) begin
			st_d = addr_ok ? ST_OK : ST_RANGE;
		end else if (bit_width > MAX_WIDTH) begin
			st_d = ST_WIDTH;
		end else if (end_pos > EW'(8 * BUF_BYTES)) begin
			st_d = ST_RANGE;
		end else begin
			st_d = ST_OK;
		end
	end

	// The field lies in words w_lo and w_lo+1, one in each bank.
	assign w_lo    = eff_off[8:6];
	assign w_hi    = {1'b0, w_lo} + 4'd1;
	assign oa_full = w_lo[2:1];
	assign ea_full = w_lo[0] ? w_hi[3:1] : {1'b0, w_lo[2:1]};
	assign eok     = {ea_full, 1'b0} < 4'(NW);
	assign ook     = {1'b0, oa_full, 1'b1} < 4'(NW);
	assign ea      = eok ? AW'(ea_full) : '0;
	assign oa      = ook ? AW'(oa_full) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= acc;
			done_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			ctl_s1.msb   <= eff_msb;
			ctl_s1.shift <= eff_off[5:0];
			ctl_s1.width <= eff_wid;
			val_s1       <= eff_val;
			st_s1        <= st_d;
			wr_s1        <= (req == REQ_WR_BYTE) || (req == REQ_INSERT);
			rd_s1        <= (req == REQ_RD_BYTE) || (req == REQ_EXTRACT);
			odd_lo_s1    <= w_lo[0];
			ea_s1        <= ea;
			oa_s1        <= oa;
			eok_s1       <= eok;
			ook_s1       <= ook;
		end
		if (v_s1) begin
			result_q <= (rd_s1 && st_s1 == ST_OK) ? extracted : 64'd0;
			status_q <= st_s1;
		end
	end

	bfei_bank #(.DEPTH(BD), .AW(AW)) u_even (
		.clk   (clk),
		.we    (we_even),
		.waddr (ea_s1),
		.wdata (odd_lo_s1 ? win_new[127:64] : win_new[63:0]),
		.re    (acc),
		.raddr (ea),
		.rdata (even_rd)
	);

	bfei_bank #(.DEPTH(BD), .AW(AW)) u_odd (
		.clk   (clk),
		.we    (we_odd),
		.waddr (oa_s1),
		.wdata (odd_lo_s1 ? win_new[63:0] : win_new[127:64]),
		.re    (acc),
		.raddr (oa),
		.rdata (odd_rd)
	);

	assign win = odd_lo_s1 ? {even_rd, odd_rd} : {odd_rd, even_rd};

	bfei_field u_field (
		.ctl       (ctl_s1),
		.value     (val_s1),
		.win       (win),
		.extracted (extracted),
		.win_new   (win_new)
	);

	assign we_even = v_s1 && wr_s1 && (st_s1 == ST_OK) && eok_s1;
	assign we_odd  = v_s1 && wr_s1 && (st_s1 == ST_OK) && ook_s1;

	assign done        = done_q;
	assign result_data = result_q;
	assign status      = status_q;

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |=> done_q)
		else $error("request in flight gave no result word");

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !v_s1)
		else $error("result word overlaps a request in flight");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q != ST_OK) |-> (result_q == 64'd0))
		else $error("error status with nonzero result");

	a_write_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(we_even || we_odd) |-> (st_s1 == ST_OK && !acc))
		else $error("buffer written on error or during a new read");

endmodule
